/* rtl/orsf_pkg.sv */
`timescale 1ns / 1ps

package orsf_pkg;

   localparam int RING_DEPTH = 16;
   localparam int PAYLOAD_WIDTH = 64;

   localparam int SEQ_WIDTH = 32;
   localparam int FIELD_PAYLOAD_WIDTH = 64;
   localparam int COUNT_WIDTH = 5;
   localparam int PTR_WIDTH = $clog2(RING_DEPTH);
   localparam int HELD_WIDTH = $clog2(RING_DEPTH + 1);

   localparam logic [COUNT_WIDTH-1:0] MAX_RESULTS = COUNT_WIDTH'(16);

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic push;
      logic load;
      logic step;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic out_free;
   } ctl_status_type;

endpackage

/* rtl/orsf_ctrl.sv */
`timescale 1ns / 1ps

module orsf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   input  orsf_pkg::ctl_status_type status,
   output orsf_pkg::ctl_cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == orsf_pkg::ACTION_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/orsf_datapath.sv */
`timescale 1ns / 1ps

module orsf_datapath (
   input  logic                                         clock,
   input  logic                                         reset,
   input  orsf_pkg::ctl_cmd_type                        cmd,
   output orsf_pkg::ctl_status_type                     status,
   input  logic [orsf_pkg::SEQ_WIDTH-1:0]               req_new_seq,
   input  logic [orsf_pkg::FIELD_PAYLOAD_WIDTH-1:0]     req_new_payload,
   input  logic [orsf_pkg::SEQ_WIDTH-1:0]               req_above_seq,
   input  logic [orsf_pkg::COUNT_WIDTH-1:0]             req_max_count,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic                                         rsp_has_entry,
   output logic [orsf_pkg::SEQ_WIDTH-1:0]               rsp_entry_seq,
   output logic [orsf_pkg::FIELD_PAYLOAD_WIDTH-1:0]     rsp_entry_payload,
   output logic [orsf_pkg::COUNT_WIDTH-1:0]             rsp_emitted_so_far,
   output logic [orsf_pkg::SEQ_WIDTH-1:0]               rsp_total_pushed,
   output logic [orsf_pkg::SEQ_WIDTH-1:0]               rsp_latest_seq,
   output logic                                         rsp_last
);

   localparam int PW = orsf_pkg::PAYLOAD_WIDTH;
   localparam int SW = orsf_pkg::SEQ_WIDTH;
   localparam int CW = orsf_pkg::COUNT_WIDTH;
   localparam int PTRW = orsf_pkg::PTR_WIDTH;
   localparam int HW = orsf_pkg::HELD_WIDTH;
   localparam int FPW = orsf_pkg::FIELD_PAYLOAD_WIDTH;

   // ring storage
   logic [SW-1:0] seq_mem [orsf_pkg::RING_DEPTH];
   logic [PW-1:0] pay_mem [orsf_pkg::RING_DEPTH];

   // ring control
   logic [PTRW-1:0] wp_ff, wp_in;
   logic [HW-1:0]   held_ff, held_in;
   logic [SW-1:0]   total_ff, total_in;
   logic [SW-1:0]   recent_ff, recent_in;

   // walk state
   logic [PTRW-1:0] idx_ff, idx_in;
   logic [HW-1:0]   remain_ff, remain_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [CW-1:0]   limit_ff, limit_in;
   logic [SW-1:0]   since_ff;
   logic            s1_valid_ff, s1_valid_in;
   logic [SW-1:0]   rd_seq_ff;
   logic [PW-1:0]   rd_pay_ff;

   // held-back result
   logic            pend_valid_ff, pend_valid_in;
   logic [SW-1:0]   pend_seq_ff;
   logic [PW-1:0]   pend_pay_ff;
   logic [CW-1:0]   pend_cnt_ff;

   // output register
   logic            out_valid_ff, out_valid_in;
   logic            out_has_ff;
   logic [SW-1:0]   out_seq_ff;
   logic [FPW-1:0]  out_pay_ff;
   logic [CW-1:0]   out_cnt_ff;
   logic [SW-1:0]   out_total_ff;
   logic [SW-1:0]   out_recent_ff;
   logic            out_last_ff;

   logic            out_free;
   logic            match;
   logic            stall;
   logic            advance;
   logic            read_en;
   logic            take;
   logic            out_write;
   logic            out_from_pend;
   logic [PTRW-1:0] oldest;
   logic [HW-1:0]   wp_ext;
   logic [HW-1:0]   wrap_gap;

   assign out_free = !out_valid_ff || rsp_ready;
   assign match    = s1_valid_ff && (rd_seq_ff > since_ff) && (n_ff < limit_ff);
   assign stall    = match && pend_valid_ff && !out_free;
   assign advance  = cmd.step && !stall;
   assign read_en  = advance && (remain_ff != '0);
   assign take     = advance && match;
   assign out_from_pend = take && pend_valid_ff;
   assign out_write = out_from_pend || cmd.finish;

   assign status.out_free  = out_free;
   assign status.walk_done = (n_ff == limit_ff) || ((remain_ff == '0) && !s1_valid_ff);

   // oldest held entry sits held_count places behind the write pointer
   assign wp_ext   = HW'(wp_ff);
   assign wrap_gap = held_ff - wp_ext;
   always_comb begin
      if (wp_ext >= held_ff) begin
         oldest = PTRW'(wp_ext - held_ff);
      end else begin
         oldest = PTRW'(HW'(orsf_pkg::RING_DEPTH) - wrap_gap);
      end
   end

   always_comb begin
      wp_in         = wp_ff;
      held_in       = held_ff;
      total_in      = total_ff;
      recent_in     = recent_ff;
      idx_in        = idx_ff;
      remain_in     = remain_ff;
      n_in          = n_ff;
      limit_in      = limit_ff;
      s1_valid_in   = s1_valid_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.push) begin
         wp_in = (wp_ff == PTRW'(orsf_pkg::RING_DEPTH - 1)) ? '0 : wp_ff + PTRW'(1);
         if (held_ff != HW'(orsf_pkg::RING_DEPTH)) begin
            held_in = held_ff + HW'(1);
         end
         total_in  = total_ff + SW'(1);
         recent_in = req_new_seq;
      end

      if (cmd.load) begin
         idx_in        = oldest;
         remain_in     = held_ff;
         n_in          = '0;
         limit_in      = (req_max_count > orsf_pkg::MAX_RESULTS) ?
                         orsf_pkg::MAX_RESULTS : req_max_count;
         s1_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (advance) begin
         s1_valid_in = read_en;
         if (read_en) begin
            idx_in    = (idx_ff == PTRW'(orsf_pkg::RING_DEPTH - 1)) ? '0 : idx_ff + PTRW'(1);
            remain_in = remain_ff - HW'(1);
         end
      end

      if (take) begin
         n_in          = n_ff + CW'(1);
         pend_valid_in = 1'b1;
      end

      if (cmd.finish) begin
         pend_valid_in = 1'b0;
         s1_valid_in   = 1'b0;
      end

      if (out_write) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         held_ff       <= '0;
         total_ff      <= '0;
         recent_ff     <= '0;
         idx_ff        <= '0;
         remain_ff     <= '0;
         n_ff          <= '0;
         limit_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         held_ff       <= held_in;
         total_ff      <= total_in;
         recent_ff     <= recent_in;
         idx_ff        <= idx_in;
         remain_ff     <= remain_in;
         n_ff          <= n_in;
         limit_ff      <= limit_in;
         s1_valid_ff   <= s1_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         seq_mem[wp_ff] <= req_new_seq;
         pay_mem[wp_ff] <= req_new_payload[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         rd_seq_ff <= seq_mem[idx_ff];
         rd_pay_ff <= pay_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         since_ff <= req_above_seq;
      end
      if (take) begin
         pend_seq_ff <= rd_seq_ff;
         pend_pay_ff <= rd_pay_ff;
         pend_cnt_ff <= n_ff + CW'(1);
      end
      if (out_write) begin
         out_total_ff  <= total_ff;
         out_recent_ff <= recent_ff;
         if (out_from_pend || pend_valid_ff) begin
            out_has_ff <= 1'b1;
            out_seq_ff <= pend_seq_ff;
            out_pay_ff <= FPW'(pend_pay_ff);
            out_cnt_ff <= pend_cnt_ff;
         end else begin
            out_has_ff <= 1'b0;
            out_seq_ff <= '0;
            out_pay_ff <= '0;
            out_cnt_ff <= '0;
         end
         out_last_ff <= cmd.finish;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_has_entry      = out_has_ff;
   assign rsp_entry_seq      = out_seq_ff;
   assign rsp_entry_payload  = out_pay_ff;
   assign rsp_emitted_so_far = out_cnt_ff;
   assign rsp_total_pushed   = out_total_ff;
   assign rsp_latest_seq     = out_recent_ff;
   assign rsp_last           = out_last_ff;

`ifndef SYNTHESIS
   held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(orsf_pkg::RING_DEPTH))
      else $error("held count beyond ring depth");

   count_in_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= limit_ff)
      else $error("emitted count beyond query limit");

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_write |-> out_free)
      else $error("output register overwritten while stalled");

   push_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (total_ff == $past(total_ff) + SW'(1)))
      else $error("push total did not advance");

   walk_no_push: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.finish) |-> !cmd.push)
      else $error("push during a snapshot walk");
`endif

endmodule

/* rtl/overwriting_ring_seq_filter_readout.sv */
`timescale 1ns / 1ps
// overwriting ring of sequence-numbered messages with a filtered snapshot readout
// req channel: one transaction per item; req_action selects a push or a snapshot
// query. a push gives no rsp transaction; a full ring loses its oldest entry. a
// query walks the held entries oldest first, one ring read per cycle while the
// walk is not halted, and gives one rsp transaction per entry whose sequence is
// above req_above_seq, up to req_max_count (values above 16 act as 16), or one
// empty transaction when nothing matches or the limit is zero. rsp_last marks the
// end. a match is held back until the next match or the end of the walk shows
// whether it is last. the walk reads through the single read port of the ring
// memory and ends early when req_max_count is reached.
// req_ready is high only between items, so the next item is taken as soon as
// the last result of a query sits in the output register.
// when rsp_ready is low and the output register is full, the walk halts at a
// match that finds a result already held back, and resumes without loss.
// reset (synchronous, active high) empties the ring and clears the totals; the
// ring contents themselves are not cleared and need no clearing pass.

module overwriting_ring_seq_filter_readout (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_action,
   input  logic [orsf_pkg::SEQ_WIDTH-1:0]           req_new_seq,
   input  logic [orsf_pkg::FIELD_PAYLOAD_WIDTH-1:0] req_new_payload,
   input  logic [orsf_pkg::SEQ_WIDTH-1:0]           req_above_seq,
   input  logic [orsf_pkg::COUNT_WIDTH-1:0]         req_max_count,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_has_entry,
   output logic [orsf_pkg::SEQ_WIDTH-1:0]           rsp_entry_seq,
   output logic [orsf_pkg::FIELD_PAYLOAD_WIDTH-1:0] rsp_entry_payload,
   output logic [orsf_pkg::COUNT_WIDTH-1:0]         rsp_emitted_so_far,
   output logic [orsf_pkg::SEQ_WIDTH-1:0]           rsp_total_pushed,
   output logic [orsf_pkg::SEQ_WIDTH-1:0]           rsp_latest_seq,
   output logic                                     rsp_last
);

   orsf_pkg::ctl_cmd_type    cmd;
   orsf_pkg::ctl_status_type status;

   orsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   orsf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_new_seq        (req_new_seq),
      .req_new_payload    (req_new_payload),
      .req_above_seq      (req_above_seq),
      .req_max_count      (req_max_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_has_entry      (rsp_has_entry),
      .rsp_entry_seq      (rsp_entry_seq),
      .rsp_entry_payload  (rsp_entry_payload),
      .rsp_emitted_so_far (rsp_emitted_so_far),
      .rsp_total_pushed   (rsp_total_pushed),
      .rsp_latest_seq     (rsp_latest_seq),
      .rsp_last           (rsp_last)
   );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int SEQ_WIDTH           = orsf_pkg::SEQ_WIDTH;
   localparam int FIELD_PAYLOAD_WIDTH = orsf_pkg::FIELD_PAYLOAD_WIDTH;
   localparam int PAYLOAD_WIDTH       = orsf_pkg::PAYLOAD_WIDTH;
   localparam int COUNT_WIDTH         = orsf_pkg::COUNT_WIDTH;
   localparam int RING_DEPTH          = orsf_pkg::RING_DEPTH;
   localparam logic [COUNT_WIDTH-1:0] MAX_RESULTS = orsf_pkg::MAX_RESULTS;

   localparam int CLOCK_PERIOD      = 10;
   localparam int RANDOM_ITEMS      = 330;
   localparam int LONG_HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES      = 24;
   localparam int RUN_LIMIT_CYCLES  = 2_000_000;
   localparam logic [FIELD_PAYLOAD_WIDTH-1:0] PAYLOAD_MASK =
      {FIELD_PAYLOAD_WIDTH{1'b1}} >> (FIELD_PAYLOAD_WIDTH - PAYLOAD_WIDTH);

   typedef struct packed {
      logic                           has_entry;
      logic [SEQ_WIDTH-1:0]           entry_seq;
      logic [FIELD_PAYLOAD_WIDTH-1:0] entry_payload;
      logic [COUNT_WIDTH-1:0]         emitted_so_far;
      logic [SEQ_WIDTH-1:0]           total_pushed;
      logic [SEQ_WIDTH-1:0]           latest_seq;
      logic                           last;
   } readout_type;

   class ring_mirror;
      logic [SEQ_WIDTH-1:0]           seq_mem [RING_DEPTH];
      logic [FIELD_PAYLOAD_WIDTH-1:0] payload_mem [RING_DEPTH];
      int unsigned                    wr_ptr;
      int unsigned                    held;
      logic [SEQ_WIDTH-1:0]           push_count;
      logic [SEQ_WIDTH-1:0]           newest_seq;
      readout_type                    due_readouts [$];
      int unsigned                    errors;
      int unsigned                    pushes;
      int unsigned                    queries;
      int unsigned                    empty_queries;
      int unsigned                    entries_read;
      int unsigned                    overwrites;

      function new();
         foreach (seq_mem[i]) begin
            seq_mem[i] = '0;
            payload_mem[i] = '0;
         end
         wr_ptr = 0;
         held = 0;
         push_count = '0;
         newest_seq = '0;
         errors = 0;
         pushes = 0;
         queries = 0;
         empty_queries = 0;
         entries_read = 0;
         overwrites = 0;
      endfunction

      function void apply_request(input logic                           act,
                                  input logic [SEQ_WIDTH-1:0]           new_seq,
                                  input logic [FIELD_PAYLOAD_WIDTH-1:0] new_payload,
                                  input logic [SEQ_WIDTH-1:0]           above_seq,
                                  input logic [COUNT_WIDTH-1:0]         max_count);
         readout_type            pending;
         logic                   have_pending;
         logic [COUNT_WIDTH-1:0] limit;
         int unsigned            idx;
         int unsigned            walked;
         int unsigned            found;
         if (act == orsf_pkg::ACTION_PUSH) begin
            seq_mem[wr_ptr] = new_seq;
            payload_mem[wr_ptr] = new_payload & PAYLOAD_MASK;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (held < RING_DEPTH)
               held++;
            else
               overwrites++;
            push_count++;
            newest_seq = new_seq;
            pushes++;
            return;
         end
         queries++;
         limit = (max_count > MAX_RESULTS) ? MAX_RESULTS : max_count;
         idx = (wr_ptr + RING_DEPTH - held) % RING_DEPTH;
         walked = 0;
         found = 0;
         have_pending = 1'b0;
         pending = '0;
         while (walked < held && found < limit) begin
            if (seq_mem[idx] > above_seq) begin
               if (have_pending)
                  due_readouts.push_back(pending);
               found++;
               pending.has_entry = 1'b1;
               pending.entry_seq = seq_mem[idx];
               pending.entry_payload = payload_mem[idx];
               pending.emitted_so_far = COUNT_WIDTH'(found);
               pending.total_pushed = push_count;
               pending.latest_seq = newest_seq;
               pending.last = 1'b0;
               have_pending = 1'b1;
            end
            idx = (idx + 1) % RING_DEPTH;
            walked++;
         end
         if (!have_pending) begin
            pending = '0;
            pending.total_pushed = push_count;
            pending.latest_seq = newest_seq;
            empty_queries++;
         end
         pending.last = 1'b1;
         due_readouts.push_back(pending);
      endfunction

      function void compare_field(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_readout(input readout_type got);
         readout_type want;
         if (due_readouts.size() == 0) begin
            $display("%0t: unexpected result, seq %h payload %h last %b",
                     $time, got.entry_seq, got.entry_payload, got.last);
            errors++;
            return;
         end
         want = due_readouts.pop_front();
         if (want.has_entry)
            entries_read++;
         compare_field("has_entry", 64'(want.has_entry), 64'(got.has_entry));
         compare_field("entry_seq", 64'(want.entry_seq), 64'(got.entry_seq));
         compare_field("entry_payload", want.entry_payload, got.entry_payload);
         compare_field("emitted_so_far", 64'(want.emitted_so_far), 64'(got.emitted_so_far));
         compare_field("total_pushed", 64'(want.total_pushed), 64'(got.total_pushed));
         compare_field("latest_seq", 64'(want.latest_seq), 64'(got.latest_seq));
         compare_field("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_action;
   logic [SEQ_WIDTH-1:0]           req_new_seq;
   logic [FIELD_PAYLOAD_WIDTH-1:0] req_new_payload;
   logic [SEQ_WIDTH-1:0]           req_above_seq;
   logic [COUNT_WIDTH-1:0]         req_max_count;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_has_entry;
   logic [SEQ_WIDTH-1:0]           rsp_entry_seq;
   logic [FIELD_PAYLOAD_WIDTH-1:0] rsp_entry_payload;
   logic [COUNT_WIDTH-1:0]         rsp_emitted_so_far;
   logic [SEQ_WIDTH-1:0]           rsp_total_pushed;
   logic [SEQ_WIDTH-1:0]           rsp_latest_seq;
   logic                           rsp_last;

   ring_mirror mirror = new();
   logic       pressure_go = 1'b0;
   int         longest_hold = 0;

   overwriting_ring_seq_filter_readout u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_new_seq        (req_new_seq),
      .req_new_payload    (req_new_payload),
      .req_above_seq      (req_above_seq),
      .req_max_count      (req_max_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_has_entry      (rsp_has_entry),
      .rsp_entry_seq      (rsp_entry_seq),
      .rsp_entry_payload  (rsp_entry_payload),
      .rsp_emitted_so_far (rsp_emitted_so_far),
      .rsp_total_pushed   (rsp_total_pushed),
      .rsp_latest_seq     (rsp_latest_seq),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input int                             gap,
                            input logic                           act,
                            input logic [SEQ_WIDTH-1:0]           new_seq,
                            input logic [FIELD_PAYLOAD_WIDTH-1:0] new_payload,
                            input logic [SEQ_WIDTH-1:0]           above_seq,
                            input logic [COUNT_WIDTH-1:0]         max_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_new_seq <= new_seq;
      req_new_payload <= new_payload;
      req_above_seq <= above_seq;
      req_max_count <= max_count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic push_msg(input logic [SEQ_WIDTH-1:0] new_seq,
                           input logic [FIELD_PAYLOAD_WIDTH-1:0] new_payload,
                           input int gap);
      send_item(gap, orsf_pkg::ACTION_PUSH, new_seq, new_payload, SEQ_WIDTH'($urandom),
                COUNT_WIDTH'($urandom));
   endtask

   task automatic query_ring(input logic [SEQ_WIDTH-1:0] above_seq,
                             input logic [COUNT_WIDTH-1:0] max_count, input int gap);
      send_item(gap, orsf_pkg::ACTION_QUERY, SEQ_WIDTH'($urandom), {$urandom, $urandom},
                above_seq, max_count);
   endtask

   // transaction monitor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         mirror.apply_request(req_action, req_new_seq, req_new_payload, req_above_seq,
                              req_max_count);
      if (!reset && rsp_valid && rsp_ready)
         mirror.match_readout({rsp_has_entry, rsp_entry_seq, rsp_entry_payload,
                               rsp_emitted_so_far, rsp_total_pushed, rsp_latest_seq,
                               rsp_last});
   end

   // receiver back-pressure
   initial begin : receiver
      int high_len;
      int low_len;
      forever begin
         if (pressure_go && longest_hold == 0) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            longest_hold = LONG_HOLD_CYCLES;
         end
         high_len = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 40);
         low_len = idle_cycles();
         rsp_ready <= 1'b1;
         repeat (high_len) @(posedge clock);
         if (low_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (low_len) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      repeat (RUN_LIMIT_CYCLES) @(posedge clock);
      $display("overwriting_ring_seq_filter_readout test failed");
      $finish;
   end

   initial begin : stimulus
      logic [SEQ_WIDTH-1:0]   seq_run;
      logic [SEQ_WIDTH-1:0]   since_pick;
      logic [COUNT_WIDTH-1:0] count_pick;
      int unsigned            roll;
      int                     burst_left;
      int                     gap;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= orsf_pkg::ACTION_PUSH;
      req_new_seq <= '0;
      req_new_payload <= '0;
      req_above_seq <= '0;
      req_max_count <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty ring
      query_ring('0, MAX_RESULTS, idle_cycles());
      query_ring('0, '0, idle_cycles());
      // extremes of sequence and payload
      push_msg('0, '0, idle_cycles());
      push_msg('1, '1, idle_cycles());
      query_ring('0, MAX_RESULTS, idle_cycles());
      query_ring('1, MAX_RESULTS, idle_cycles());
      query_ring('0, '0, idle_cycles());
      // fill past the depth so the oldest entry is overwritten
      for (int k = 0; k < RING_DEPTH - 1; k++)
         push_msg(SEQ_WIDTH'(100 + k), (k % 2) ? {32{2'b01}} : {32{2'b10}}, idle_cycles());
      query_ring('0, '1, idle_cycles());
      query_ring(SEQ_WIDTH'(107), COUNT_WIDTH'(3), idle_cycles());
      query_ring('0, COUNT_WIDTH'(1), idle_cycles());

      pressure_go = 1'b1;
      seq_run = 32'h0000_1000;
      burst_left = 0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (burst_left == 0 && $urandom_range(0, 19) == 0)
            burst_left = $urandom_range(10, 30);
         if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else begin
            gap = idle_cycles();
         end
         if ($urandom_range(0, 99) < 60) begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
               seq_run = seq_run + $urandom_range(1, 3);
            else if (roll < 85)
               seq_run = $urandom;
            else if (roll < 92)
               seq_run = 32'hFFFF_FFFF - $urandom_range(0, 8);
            else
               seq_run = seq_run - $urandom_range(1, 5);
            push_msg(seq_run, {$urandom, $urandom}, gap);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
               since_pick = '0;
            else if (roll < 35)
               since_pick = '1;
            else if (roll < 45)
               since_pick = $urandom;
            else
               since_pick = mirror.newest_seq - $urandom_range(0, 20);
            roll = $urandom_range(0, 99);
            if (roll < 15)
               count_pick = '0;
            else if (roll < 30)
               count_pick = COUNT_WIDTH'($urandom_range(17, 31));
            else
               count_pick = COUNT_WIDTH'($urandom_range(1, 16));
            query_ring(since_pick, count_pick, gap);
         end
      end
      req_valid <= 1'b0;

      while (mirror.due_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pushes (%0d overwrote the oldest entry), %0d snapshot queries",
               mirror.pushes, mirror.overwrites, mirror.queries);
      $display("%0d entries read back, %0d empty answers, one receiver hold of %0d cycles",
               mirror.entries_read, mirror.empty_queries, longest_hold);
      if (mirror.errors == 0 && mirror.due_readouts.size() == 0) begin
         $display("overwriting_ring_seq_filter_readout test passed");
      end else begin
         $display("%0d errors, %0d results still pending", mirror.errors,
                  mirror.due_readouts.size());
         $display("overwriting_ring_seq_filter_readout test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/orsf_pkg.sv
rtl/orsf_ctrl.sv
rtl/orsf_datapath.sv
rtl/overwriting_ring_seq_filter_readout.sv
bench/testbench.sv
